@@ sv/ucs_pkg.sv @@
package ucs_pkg;

  // Parse phase of the URL currently streaming in.
  typedef enum logic [2:0] {
    PH_SCHEME = 3'd0,
    PH_HOST   = 3'd1,
    PH_PORT   = 3'd2,
    PH_PATH   = 3'd3,
    PH_QUERY  = 3'd4,
    PH_FRAG   = 3'd5
  } phase_e;

  // Tag carried by every result beat.
  typedef enum logic [2:0] {
    COMP_SCHEME = 3'd0,
    COMP_DELIM  = 3'd1,
    COMP_HOST   = 3'd2,
    COMP_PORT   = 3'd3,
    COMP_PATH   = 3'd4,
    COMP_QUERY  = 3'd5,
    COMP_FRAG   = 3'd6
  } comp_e;

  localparam int unsigned ResPerItem = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] ChColon    = 8'h3A;
  localparam logic [7:0] ChSlash    = 8'h2F;
  localparam logic [7:0] ChQuestion = 8'h3F;
  localparam logic [7:0] ChHash     = 8'h23;
  localparam logic [7:0] ChDigit0   = 8'h30;
  localparam logic [7:0] ChDigit9   = 8'h39;
  localparam logic [7:0] ChUpperA   = 8'h41;
  localparam logic [7:0] ChUpperZ   = 8'h5A;
  localparam logic [7:0] CaseOffset = 8'h20;

  localparam logic [2:0]  HostLen = 3'd5;
  localparam logic [2:0]  NoMatch = 3'd6;
  localparam logic [15:0] PortMax = 16'hFFFF;

  // One queue entry: all result beats caused by one input byte.
  typedef struct packed {
    logic [1:0]                   cnt;
    logic [ResPerItem-1:0][7:0]   bytes;
    comp_e [ResPerItem-1:0]       comps;
    logic                         last;
    logic [15:0]                  port;
    logic                         scheme_found;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= ChUpperA && b <= ChUpperZ) begin
      r = b + CaseOffset;
    end
    return r;
  endfunction

  // Characters of the host name that selects local mode.
  function automatic logic [7:0] local_char(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h6C;
      3'd1:    r = 8'h6F;
      3'd2:    r = 8'h63;
      3'd3:    r = 8'h61;
      3'd4:    r = 8'h6C;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

@@ sv/ucs_in_if.sv @@
interface ucs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] url_byte;
  logic       end_of_url;

  modport source (output valid, output url_byte, output end_of_url, input ready);
  modport sink (input valid, input url_byte, input end_of_url, output ready);
endinterface

@@ sv/ucs_out_if.sv @@
interface ucs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [2:0]  component;
  logic        final_item;
  logic [15:0] port_number;
  logic        scheme_found;

  modport source (output valid, output out_byte, output component, output final_item,
                  output port_number, output scheme_found, input ready);
  modport sink (input valid, input out_byte, input component, input final_item,
                input port_number, input scheme_found, output ready);
endinterface

@@ sv/ucs_front.sv @@
module ucs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  ucs_in_if.sink            in_i,
  input  ucs_pkg::qstat_t   qstat_i,
  output logic              push_o,
  output ucs_pkg::entry_t   entry_o
);

  ucs_pkg::phase_e phase_q, phase_d;
  logic [7:0]  d0_q, d0_d, d1_q, d1_d;
  logic [1:0]  dcnt_q, dcnt_d;
  logic [2:0]  host_q, host_d;
  logic [15:0] port_q, port_d;
  logic        pdone_q, pdone_d;
  logic        fire;

  assign in_i.ready = !qstat_i.full;
  assign fire       = in_i.valid && in_i.ready;

  always_comb begin
    logic [7:0]  b;
    logic [1:0]  n;
    logic [19:0] prod;
    logic [19:0] sum;
    b       = in_i.url_byte;
    n       = 2'd0;
    prod    = '0;
    sum     = '0;
    phase_d = phase_q;
    d0_d    = d0_q;
    d1_d    = d1_q;
    dcnt_d  = dcnt_q;
    host_d  = host_q;
    port_d  = port_q;
    pdone_d = pdone_q;
    entry_o = '0;

    unique case (phase_q)
      ucs_pkg::PH_SCHEME: begin
        if (dcnt_q == 2'd2 && d0_q == ucs_pkg::ChColon && d1_q == ucs_pkg::ChSlash &&
            b == ucs_pkg::ChSlash) begin
          entry_o.bytes[0] = d0_q;
          entry_o.comps[0] = ucs_pkg::COMP_DELIM;
          entry_o.bytes[1] = d1_q;
          entry_o.comps[1] = ucs_pkg::COMP_DELIM;
          entry_o.bytes[2] = b;
          entry_o.comps[2] = ucs_pkg::COMP_DELIM;
          n       = 2'd3;
          dcnt_d  = 2'd0;
          phase_d = ucs_pkg::PH_HOST;
        end else if (dcnt_q == 2'd2) begin
          entry_o.bytes[0] = ucs_pkg::to_lower(d0_q);
          entry_o.comps[0] = ucs_pkg::COMP_SCHEME;
          n    = 2'd1;
          d0_d = d1_q;
          d1_d = b;
        end else begin
          if (dcnt_q == 2'd0) begin
            d0_d = b;
          end else begin
            d1_d = b;
          end
          dcnt_d = dcnt_q + 2'd1;
        end
      end
      ucs_pkg::PH_HOST: begin
        n = 2'd1;
        entry_o.bytes[0] = b;
        entry_o.comps[0] = ucs_pkg::COMP_DELIM;
        if (b == ucs_pkg::ChColon && host_q == ucs_pkg::HostLen) begin
          phase_d = ucs_pkg::PH_PATH;
        end else if (b == ucs_pkg::ChColon) begin
          phase_d = ucs_pkg::PH_PORT;
        end else if (b == ucs_pkg::ChSlash) begin
          phase_d = ucs_pkg::PH_PATH;
        end else if (b == ucs_pkg::ChQuestion) begin
          phase_d = ucs_pkg::PH_QUERY;
        end else if (b == ucs_pkg::ChHash) begin
          phase_d = ucs_pkg::PH_FRAG;
        end else begin
          entry_o.comps[0] = ucs_pkg::COMP_HOST;
          if (host_q < ucs_pkg::HostLen && b == ucs_pkg::local_char(host_q)) begin
            host_d = host_q + 3'd1;
          end else begin
            host_d = ucs_pkg::NoMatch;
          end
        end
      end
      ucs_pkg::PH_PORT: begin
        n = 2'd1;
        entry_o.bytes[0] = b;
        entry_o.comps[0] = ucs_pkg::COMP_DELIM;
        if (b == ucs_pkg::ChSlash) begin
          phase_d = ucs_pkg::PH_PATH;
        end else if (b == ucs_pkg::ChQuestion) begin
          phase_d = ucs_pkg::PH_QUERY;
        end else if (b == ucs_pkg::ChHash) begin
          phase_d = ucs_pkg::PH_FRAG;
        end else begin
          entry_o.comps[0] = ucs_pkg::COMP_PORT;
          if (!pdone_q && b >= ucs_pkg::ChDigit0 && b <= ucs_pkg::ChDigit9) begin
            // Decimal digits sit at 0x30..0x39, so the low nibble is the value.
            prod = {4'd0, port_q} * 20'd10;
            sum  = prod + {16'd0, b[3:0]};
            port_d = (sum > {4'd0, ucs_pkg::PortMax}) ? ucs_pkg::PortMax : sum[15:0];
          end else begin
            pdone_d = 1'b1;
          end
        end
      end
      ucs_pkg::PH_PATH: begin
        n = 2'd1;
        entry_o.bytes[0] = b;
        entry_o.comps[0] = ucs_pkg::COMP_DELIM;
        if (b == ucs_pkg::ChQuestion) begin
          phase_d = ucs_pkg::PH_QUERY;
        end else if (b == ucs_pkg::ChHash) begin
          phase_d = ucs_pkg::PH_FRAG;
        end else begin
          entry_o.comps[0] = ucs_pkg::COMP_PATH;
        end
      end
      ucs_pkg::PH_QUERY: begin
        n = 2'd1;
        entry_o.bytes[0] = b;
        if (b == ucs_pkg::ChHash) begin
          entry_o.comps[0] = ucs_pkg::COMP_DELIM;
          phase_d = ucs_pkg::PH_FRAG;
        end else begin
          entry_o.comps[0] = ucs_pkg::COMP_QUERY;
        end
      end
      default: begin
        n = 2'd1;
        entry_o.bytes[0] = b;
        entry_o.comps[0] = ucs_pkg::COMP_FRAG;
      end
    endcase

    if (in_i.end_of_url) begin
      // Flush the held scheme bytes behind whatever this byte produced.
      if (dcnt_d != 2'd0) begin
        entry_o.bytes[n] = ucs_pkg::to_lower(d0_d);
        entry_o.comps[n] = ucs_pkg::COMP_SCHEME;
        n = n + 2'd1;
      end
      if (dcnt_d == 2'd2) begin
        entry_o.bytes[n] = ucs_pkg::to_lower(d1_d);
        entry_o.comps[n] = ucs_pkg::COMP_SCHEME;
        n = n + 2'd1;
      end
      entry_o.last         = 1'b1;
      entry_o.port         = port_d;
      entry_o.scheme_found = (phase_d != ucs_pkg::PH_SCHEME);
      phase_d = ucs_pkg::PH_SCHEME;
      d0_d    = 8'd0;
      d1_d    = 8'd0;
      dcnt_d  = 2'd0;
      host_d  = 3'd0;
      port_d  = 16'd0;
      pdone_d = 1'b0;
    end

    entry_o.cnt = n;
    push_o      = fire && (n != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ucs_pkg::PH_SCHEME;
      d0_q    <= 8'd0;
      d1_q    <= 8'd0;
      dcnt_q  <= 2'd0;
      host_q  <= 3'd0;
      port_q  <= 16'd0;
      pdone_q <= 1'b0;
    end else if (fire) begin
      phase_q <= phase_d;
      d0_q    <= d0_d;
      d1_q    <= d1_d;
      dcnt_q  <= dcnt_d;
      host_q  <= host_d;
      port_q  <= port_d;
      pdone_q <= pdone_d;
    end
  end

endmodule

@@ sv/ucs_queue.sv @@
module ucs_queue #(
  parameter int unsigned DEPTH = ucs_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ucs_pkg::entry_t  entry_i,
  input  logic             pop_i,
  output ucs_pkg::entry_t  head_o,
  output ucs_pkg::qstat_t  qstat_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  ucs_pkg::entry_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign qstat_o.full  = (cnt_q == CntW'(DEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

@@ sv/ucs_back.sv @@
module ucs_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ucs_pkg::entry_t  head_i,
  input  ucs_pkg::qstat_t  qstat_i,
  output logic             pop_o,
  ucs_out_if.source        out_o
);

  logic [1:0] idx_q, idx_d;
  logic       last_beat;
  logic       fire;

  assign last_beat = (idx_q == (head_i.cnt - 2'd1));
  assign fire      = out_o.valid && out_o.ready;
  assign pop_o     = fire && last_beat;

  assign out_o.valid        = !qstat_i.empty;
  assign out_o.out_byte     = head_i.bytes[idx_q];
  assign out_o.component    = head_i.comps[idx_q];
  assign out_o.final_item   = head_i.last && last_beat;
  assign out_o.port_number  = out_o.final_item ? head_i.port : 16'd0;
  assign out_o.scheme_found = out_o.final_item && head_i.scheme_found;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = last_beat ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

@@ sv/url_component_splitter.sv @@
// URL component splitter. Feed a URL one byte per beat on in_i, with end_of_url set on its last
// byte; each byte comes back on out_o tagged as scheme, delimiter, host, port text, path, query
// or fragment. Scheme bytes come out lower-cased and two bytes late, because the block holds
// them back until it knows whether they start the first "://"; a URL without "://" comes out
// entirely as scheme with scheme_found low on its final beat. The final beat of a URL carries
// the port (decimal, saturating at 65535, zero if absent) and scheme_found; on all other beats
// both read zero. The input side takes one byte per cycle whenever the result queue has room.
// The output side delivers one result beat per ready cycle, and a byte causes zero to three
// beats: three for the byte that completes "://" or for a final byte that flushes held scheme
// bytes, none for the first two scheme bytes. The sustained rate is therefore one byte per cycle
// for ordinary text, and the output port sets the pace for bytes that produce several beats; the
// queue of QUEUE_DEPTH entries between the classifier and the output stage absorbs the bursts.
module url_component_splitter #(
  parameter int unsigned QUEUE_DEPTH = ucs_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ucs_in_if.sink      in_i,
  ucs_out_if.source   out_o
);

  // Classifier-to-queue and queue-to-output connections.
  ucs_pkg::entry_t entry;
  ucs_pkg::entry_t head;
  ucs_pkg::qstat_t qstat;
  logic            push;
  logic            pop;

  // The front end runs the phase machine and packs every beat that one input byte causes
  // into a single queue entry, so it waits for the output side only when the queue is full.
  ucs_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .qstat_i (qstat),
    .push_o  (push),
    .entry_o (entry)
  );

  ucs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  // The back end walks the beats of the head entry, one per accepted output beat.
  ucs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .qstat_i (qstat),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  // A final byte always produces at least one beat, so its entry must be queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.end_of_url) |=> !qstat.empty)
    else $error("final byte of a URL produced no queued beats");

  // The queue never holds an entry with no beats in it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (entry.cnt != 2'd0))
    else $error("empty entry pushed into the result queue");

  // Port and scheme status only appear on the last beat of a URL.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.final_item) |-> (out_o.port_number == 16'd0 && !out_o.scheme_found))
    else $error("URL status shown on a beat that is not final");

  // A popped entry must have been the one whose last beat just left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (out_o.valid && out_o.ready))
    else $error("queue entry released without an output beat");

endmodule
